/* rtl/core/ffc_pkg.sv */
// ffc_pkg: shared constants, types and tables for the free-fly camera update block
// used by ffc_ctrl, ffc_dp and free_fly_camera_update; depends on nothing
package ffc_pkg;

  // default parameter values
  localparam int POS_WIDTH_DEF  = 32;
  localparam int ANGLE_FRAC_DEF = 16;
  localparam int VEC_FRAC_DEF   = 14;

  // stream word widths
  localparam int DATA_IN_W  = 64;
  localparam int DATA_OUT_W = 240;

  // configuration port
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;
  localparam logic [CFG_IDX_W-1:0] REG_MOUSE_SENS = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MOVE_SPEED = 2'd1;
  localparam logic [15:0] SENS_RESET  = 16'd6554;
  localparam logic [15:0] SPEED_RESET = 16'd640;

  // sequencing
  localparam int CNT_W         = 5;
  localparam int WRAP_STEPS    = 8;
  localparam int CORDIC_STEPS  = 24;
  localparam int BASIS_STEPS   = 4;
  localparam int MOVE_STEPS    = 6;

  // cordic: angle in degrees with 24 fraction bits, x/y with 30 fraction bits
  localparam int ZW = 34;
  localparam int XW = 33;
  localparam int Z_FRAC = 24;
  localparam logic signed [XW-1:0] CORDIC_INV_GAIN = 33'sd652032874;
  localparam logic signed [ZW-1:0] D90_Q24  = 34'sd1509949440;
  localparam logic signed [ZW-1:0] D180_Q24 = 34'sd3019898880;

  localparam int PITCH_LIMIT_DEG = 89;
  localparam int YAW_RESET_DEG   = 90;

  function automatic logic signed [ZW-1:0] atan_deg(input logic [CNT_W-1:0] i);
    logic signed [ZW-1:0] a;
    case (i)
      5'd0:    a = 34'sd754974720;
      5'd1:    a = 34'sd445687602;
      5'd2:    a = 34'sd235489088;
      5'd3:    a = 34'sd119537938;
      5'd4:    a = 34'sd60000934;
      5'd5:    a = 34'sd30029717;
      5'd6:    a = 34'sd15018523;
      5'd7:    a = 34'sd7509720;
      5'd8:    a = 34'sd3754917;
      5'd9:    a = 34'sd1877466;
      5'd10:   a = 34'sd938734;
      5'd11:   a = 34'sd469367;
      5'd12:   a = 34'sd234684;
      5'd13:   a = 34'sd117342;
      5'd14:   a = 34'sd58671;
      5'd15:   a = 34'sd29335;
      5'd16:   a = 34'sd14668;
      5'd17:   a = 34'sd7334;
      5'd18:   a = 34'sd3667;
      5'd19:   a = 34'sd1833;
      5'd20:   a = 34'sd917;
      5'd21:   a = 34'sd458;
      5'd22:   a = 34'sd229;
      5'd23:   a = 34'sd115;
      default: a = '0;
    endcase
    return a;
  endfunction

  // controller to datapath commands
  typedef struct packed {
    logic             capture;
    logic             load;
    logic             angle;
    logic             wrap;
    logic             setup;
    logic             rotate;
    logic             round;
    logic             basis;
    logic             move;
    logic             out_load;
    logic [CNT_W-1:0] idx;
  } ffc_cmd_t;

  // datapath to controller status
  typedef struct packed {
    logic look;
    logic out_free;
  } ffc_stat_t;

endpackage

/* rtl/core/ffc_ctrl.sv */
// ffc_ctrl: sequencer for the camera update, issues per-cycle datapath commands
// depends on ffc_pkg
module ffc_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  ffc_pkg::ffc_stat_t  stat,
  output ffc_pkg::ffc_cmd_t   cmd
);

  typedef enum logic [3:0] {
    S_IDLE, S_LOAD, S_ANGLE, S_WRAP, S_SETUP, S_ROTATE,
    S_ROUND, S_BASIS, S_MOVE, S_DONE
  } state_t;

  state_t                    state;
  logic [ffc_pkg::CNT_W-1:0] cnt;
  logic                      init;

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_SETUP;
      cnt      <= '0;
      init     <= 1'b1;
      in_ready <= 1'b0;
    end else begin
      case (state)
        S_IDLE: begin
          if (in_valid && in_ready) begin
            state    <= S_LOAD;
            in_ready <= 1'b0;
          end
        end
        S_LOAD: begin
          cnt   <= '0;
          state <= stat.look ? S_ANGLE : S_MOVE;
        end
        S_ANGLE: begin
          cnt   <= '0;
          state <= S_WRAP;
        end
        S_WRAP: begin
          if (cnt == ffc_pkg::CNT_W'(ffc_pkg::WRAP_STEPS - 1)) begin
            state <= S_SETUP;
          end else begin
            cnt <= cnt + 1'b1;
          end
        end
        S_SETUP: begin
          cnt   <= '0;
          state <= S_ROTATE;
        end
        S_ROTATE: begin
          if (cnt == ffc_pkg::CNT_W'(ffc_pkg::CORDIC_STEPS - 1)) begin
            state <= S_ROUND;
          end else begin
            cnt <= cnt + 1'b1;
          end
        end
        S_ROUND: begin
          cnt   <= '0;
          state <= S_BASIS;
        end
        S_BASIS: begin
          if (cnt == ffc_pkg::CNT_W'(ffc_pkg::BASIS_STEPS - 1)) begin
            cnt <= '0;
            if (init) begin
              init     <= 1'b0;
              state    <= S_IDLE;
              in_ready <= 1'b1;
            end else begin
              state <= S_MOVE;
            end
          end else begin
            cnt <= cnt + 1'b1;
          end
        end
        S_MOVE: begin
          if (cnt == ffc_pkg::CNT_W'(ffc_pkg::MOVE_STEPS - 1)) begin
            state <= S_DONE;
          end else begin
            cnt <= cnt + 1'b1;
          end
        end
        S_DONE: begin
          if (stat.out_free) begin
            state    <= S_IDLE;
            in_ready <= 1'b1;
          end
        end
        default: begin
          state    <= S_IDLE;
          in_ready <= 1'b1;
        end
      endcase
    end
  end

  always_comb begin
    cmd          = '0;
    cmd.idx      = cnt;
    cmd.capture  = (state == S_IDLE) && in_valid && in_ready;
    cmd.load     = (state == S_LOAD);
    cmd.angle    = (state == S_ANGLE);
    cmd.wrap     = (state == S_WRAP);
    cmd.setup    = (state == S_SETUP);
    cmd.rotate   = (state == S_ROTATE);
    cmd.round    = (state == S_ROUND);
    cmd.basis    = (state == S_BASIS);
    cmd.move     = (state == S_MOVE);
    cmd.out_load = (state == S_DONE) && stat.out_free;
  end

endmodule

/* rtl/core/ffc_dp.sv */
// ffc_dp: camera datapath - angle update and wrap, two-lane cordic, basis, movement
// depends on ffc_pkg; driven by ffc_ctrl commands
module ffc_dp #(
  parameter int POS_W = ffc_pkg::POS_WIDTH_DEF,
  parameter int AFB   = ffc_pkg::ANGLE_FRAC_DEF,
  parameter int VFB   = ffc_pkg::VEC_FRAC_DEF
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic [ffc_pkg::DATA_IN_W-1:0]      in_data,
  input  logic                               cfg_valid,
  input  logic [ffc_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [ffc_pkg::CFG_DATA_W-1:0]     cfg_data,
  input  ffc_pkg::ffc_cmd_t                  cmd,
  output ffc_pkg::ffc_stat_t                 stat,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic [ffc_pkg::DATA_OUT_W-1:0]     out_data
);

  localparam int AW  = AFB + 9;
  localparam int TW  = AFB + 18;
  localparam int VW  = VFB + 2;
  localparam int SHL = (AFB >= 16) ? AFB - 16 : 0;
  localparam int SHR = (AFB >= 16) ? 0 : 16 - AFB;
  localparam int SW  = 34 + SHL;
  localparam int CW  = VW + 4;
  localparam int MW  = CW + 33;
  localparam int DW  = 31;
  localparam int RW  = ((POS_W > DW) ? POS_W : DW) + 1;
  localparam int PX  = (POS_W > 32) ? POS_W : 32;
  localparam int VX  = (VW > 16) ? VW : 16;
  localparam int ZSH = ffc_pkg::Z_FRAC - AFB;

  localparam logic signed [TW-1:0] HALF = TW'(180) << AFB;
  localparam logic signed [TW-1:0] FULL = TW'(360) << AFB;
  localparam logic signed [TW-1:0] BIAS = FULL << (ffc_pkg::WRAP_STEPS - 1);
  localparam logic signed [TW-1:0] PLIM = TW'(ffc_pkg::PITCH_LIMIT_DEG) << AFB;
  localparam logic signed [AW-1:0] YAW_RST = -(AW'(ffc_pkg::YAW_RESET_DEG) << AFB);
  localparam int XW_L = ffc_pkg::XW;
  localparam logic signed [XW_L-1:0] VONE_X = XW_L'(1) << VFB;
  localparam logic signed [XW_L-1:0] QRND = XW_L'(1) << (29 - VFB);
  localparam logic signed [MW-1:0] MRND = MW'(1) << (VFB + 7);
  localparam logic signed [RW-1:0] PMAX = RW'((64'sd1 <<< (POS_W - 1)) - 64'sd1);
  localparam logic signed [RW-1:0] PMIN = -PMAX - RW'(1);

  // config registers
  logic [15:0]        sens;
  logic [15:0]        speed;

  // captured input word
  logic [15:0]        dt;
  logic signed [15:0] dx;
  logic signed [15:0] dy;
  logic [6:0]         keys;
  logic               look;

  // architectural state
  logic signed [AW-1:0]    yaw;
  logic signed [AW-1:0]    pitch;
  logic signed [POS_W-1:0] pos [3];
  logic signed [VW-1:0]    basis [9];

  // work registers
  logic signed [32:0]           prod_x;
  logic signed [32:0]           prod_y;
  logic [31:0]                  vel;
  logic signed [TW-1:0]         t;
  logic signed [ffc_pkg::ZW-1:0] z [2];
  logic signed [XW_L-1:0]       x [2];
  logic signed [XW_L-1:0]       y [2];
  logic [1:0]                   flip;
  logic signed [VW-1:0]         sy, cy, sp, cp;
  logic signed [MW-1:0]         mprod;

  function automatic logic signed [VW-1:0] q30_to_vec(input logic signed [XW_L-1:0] v);
    logic signed [XW_L-1:0] r;
    r = (v + QRND) >>> (30 - VFB);
    if (r > VONE_X) r = VONE_X;
    if (r < -VONE_X) r = -VONE_X;
    return VW'(r);
  endfunction

  function automatic logic signed [VW-1:0] vmul(input logic signed [VW-1:0] a,
                                                input logic signed [VW-1:0] b);
    logic signed [2*VW-1:0] p;
    p = (2*VW)'(a) * (2*VW)'(b);
    p = (p + ((2*VW)'(1) <<< (VFB - 1))) >>> VFB;
    return VW'(p);
  endfunction

  // angle step and wrap
  logic signed [SW-1:0] wx, wy;
  logic signed [TW-1:0] step_x, step_y, pn, thr, t_red;
  logic [2:0]           wk;

  always_comb begin
    wx = SW'(prod_x);
    wx = wx <<< SHL;
    wx = wx >>> SHR;
    wy = SW'(prod_y);
    wy = wy <<< SHL;
    wy = wy >>> SHR;
    step_x = TW'(wx);
    step_y = TW'(wy);
    pn = TW'(pitch) - step_y;
    if (pn > PLIM) pn = PLIM;
    if (pn < -PLIM) pn = -PLIM;
    wk = 3'(ffc_pkg::WRAP_STEPS - 1) - cmd.idx[2:0];
    thr = FULL << wk;
    t_red = (t >= thr) ? t - thr : t;
  end

  // cordic lanes: lane 0 yaw, lane 1 pitch
  logic signed [ffc_pkg::ZW-1:0] z0 [2];
  logic signed [ffc_pkg::ZW-1:0] at;
  logic signed [XW_L-1:0]        xs [2];
  logic signed [XW_L-1:0]        ys [2];
  logic signed [XW_L-1:0]        xf [2];
  logic signed [XW_L-1:0]        yf [2];

  always_comb begin
    z0[0] = ffc_pkg::ZW'(yaw) <<< ZSH;
    z0[1] = ffc_pkg::ZW'(pitch) <<< ZSH;
    at = ffc_pkg::atan_deg(cmd.idx);
    for (int l = 0; l < 2; l++) begin
      xs[l] = x[l] >>> cmd.idx;
      ys[l] = y[l] >>> cmd.idx;
      xf[l] = flip[l] ? -x[l] : x[l];
      yf[l] = flip[l] ? -y[l] : y[l];
    end
  end

  // basis product
  logic signed [VW-1:0] ba, bb, bprod;

  always_comb begin
    case (cmd.idx[1:0])
      2'd0:    begin ba = cy; bb = cp; end
      2'd1:    begin ba = sy; bb = cp; end
      2'd2:    begin ba = cy; bb = sp; end
      default: begin ba = sy; bb = sp; end
    endcase
    bprod = vmul(ba, bb);
  end

  // movement: combine key directions per axis, then one multiply by velocity
  logic [1:0]             ax;
  logic signed [VW-1:0]   vf, vr, vu;
  logic signed [CW-1:0]   c;
  logic signed [MW-1:0]   d_w;
  logic signed [DW-1:0]   d;
  logic signed [RW-1:0]   r_sum;
  logic signed [POS_W-1:0] pos_a;

  always_comb begin
    ax = cmd.idx[2:1];
    case (ax)
      2'd0:    begin vf = basis[0]; vr = basis[3]; vu = basis[6]; pos_a = pos[0]; end
      2'd1:    begin vf = basis[1]; vr = basis[4]; vu = basis[7]; pos_a = pos[1]; end
      default: begin vf = basis[2]; vr = basis[5]; vu = basis[8]; pos_a = pos[2]; end
    endcase
    c = '0;
    if (keys[1]) c = c + CW'(vf);
    if (keys[2]) c = c - CW'(vf);
    if (keys[3]) c = c - CW'(vr);
    if (keys[4]) c = c + CW'(vr);
    if (keys[5]) c = c + CW'(vu);
    if (keys[6]) c = c - CW'(vu);
    if (keys[0]) c = c + (c <<< 1);
    d_w = (mprod + MRND) >>> (VFB + 8);
    d = DW'(d_w);
    r_sum = RW'(pos_a) + RW'(d);
    if (r_sum > PMAX) r_sum = PMAX;
    if (r_sum < PMIN) r_sum = PMIN;
  end

  assign stat.look     = look;
  assign stat.out_free = !out_valid || out_ready;

  // control state and architectural registers
  always_ff @(posedge clk) begin
    if (rst) begin
      sens      <= ffc_pkg::SENS_RESET;
      speed     <= ffc_pkg::SPEED_RESET;
      yaw       <= YAW_RST;
      pitch     <= '0;
      pos[0]    <= '0;
      pos[1]    <= '0;
      pos[2]    <= '0;
      out_valid <= 1'b0;
    end else begin
      if (cfg_valid) begin
        case (cfg_index)
          ffc_pkg::REG_MOUSE_SENS: sens  <= cfg_data;
          ffc_pkg::REG_MOVE_SPEED: speed <= cfg_data;
          default: ;
        endcase
      end
      if (cmd.angle) pitch <= AW'(pn);
      if (cmd.wrap && (cmd.idx == ffc_pkg::CNT_W'(ffc_pkg::WRAP_STEPS - 1))) begin
        yaw <= AW'(t_red - HALF);
      end
      if (cmd.move && cmd.idx[0]) begin
        case (ax)
          2'd0:    pos[0] <= POS_W'(r_sum);
          2'd1:    pos[1] <= POS_W'(r_sum);
          default: pos[2] <= POS_W'(r_sum);
        endcase
      end
      if (cmd.out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      dt   <= in_data[15:0];
      look <= in_data[16] & in_data[17];
      dx   <= in_data[33:18];
      dy   <= in_data[49:34];
      keys <= in_data[56:50];
    end
    if (cmd.load) begin
      prod_x <= 33'(dx) * 33'($signed({1'b0, sens}));
      prod_y <= 33'(dy) * 33'($signed({1'b0, sens}));
      vel    <= 32'(speed) * 32'(dt);
    end
    if (cmd.angle) t <= TW'(yaw) + step_x + HALF + BIAS;
    if (cmd.wrap) t <= t_red;
    if (cmd.setup) begin
      for (int l = 0; l < 2; l++) begin
        x[l] <= ffc_pkg::CORDIC_INV_GAIN;
        y[l] <= '0;
        if (z0[l] > ffc_pkg::D90_Q24) begin
          z[l]    <= z0[l] - ffc_pkg::D180_Q24;
          flip[l] <= 1'b1;
        end else if (z0[l] < -ffc_pkg::D90_Q24) begin
          z[l]    <= z0[l] + ffc_pkg::D180_Q24;
          flip[l] <= 1'b1;
        end else begin
          z[l]    <= z0[l];
          flip[l] <= 1'b0;
        end
      end
    end
    if (cmd.rotate) begin
      for (int l = 0; l < 2; l++) begin
        if (z[l] >= 0) begin
          x[l] <= x[l] - ys[l];
          y[l] <= y[l] + xs[l];
          z[l] <= z[l] - at;
        end else begin
          x[l] <= x[l] + ys[l];
          y[l] <= y[l] - xs[l];
          z[l] <= z[l] + at;
        end
      end
    end
    if (cmd.round) begin
      sy <= q30_to_vec(yf[0]);
      cy <= q30_to_vec(xf[0]);
      sp <= q30_to_vec(yf[1]);
      cp <= q30_to_vec(xf[1]);
    end
    if (cmd.basis) begin
      case (cmd.idx[1:0])
        2'd0: begin
          basis[0] <= bprod;
          basis[1] <= sp;
          basis[3] <= -sy;
          basis[4] <= '0;
          basis[5] <= cy;
          basis[7] <= cp;
        end
        2'd1:    basis[2] <= bprod;
        2'd2:    basis[6] <= -bprod;
        default: basis[8] <= -bprod;
      endcase
    end
    if (cmd.move && !cmd.idx[0]) begin
      mprod <= MW'(c) * MW'($signed({1'b0, vel}));
    end
    if (cmd.out_load) begin
      out_data[31:0]    <= 32'(PX'(pos[0]));
      out_data[63:32]   <= 32'(PX'(pos[1]));
      out_data[95:64]   <= 32'(PX'(pos[2]));
      for (int j = 0; j < 9; j++) begin
        out_data[96 + 16*j +: 16] <= 16'(VX'(basis[j]));
      end
    end
  end

endmodule

/* rtl/core/free_fly_camera_update.sv */
// free_fly_camera_update: top level of the fly camera update block
// depends on ffc_pkg, ffc_ctrl and ffc_dp
//
// one input word per rendered frame on the s_ stream; one result word per input
// word on the m_ stream. configuration writes (mouse sensitivity, move speed)
// come over the cfg channel, which is always ready; write only while idle.
// a look tick (hovered and button held) updates yaw/pitch, wraps yaw into
// [-180, 180) with an 8-step compare-subtract loop, runs yaw and pitch through
// two cordic lanes side by side (24 iterations), then forms the basis with one
// shared multiplier. movement shares one multiplier across the axes, with a
// multiply and then a position update per axis.
// the cordic iterations dominate the work on a look tick. one word is in
// flight at a time: a new word is taken only after the last result has been
// loaded into the output register.
// after reset the block builds the initial basis
// (yaw -90, pitch 0) with s_tready low, then comes up ready.
// the result sits in an output register; if the receiver stalls, the block
// finishes the next word and then waits until the held result is taken.
module free_fly_camera_update #(
  parameter int POS_WIDTH       = ffc_pkg::POS_WIDTH_DEF,
  parameter int ANGLE_FRAC_BITS = ffc_pkg::ANGLE_FRAC_DEF,
  parameter int VEC_FRAC_BITS   = ffc_pkg::VEC_FRAC_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           s_tvalid,
  output logic                           s_tready,
  // time_step[15:0], viewport_hovered[16], look_button_held[17],
  // mouse_dx[33:18], mouse_dy[49:34], keys_held[56:50], zero fill above
  input  logic [ffc_pkg::DATA_IN_W-1:0]  s_tdata,
  output logic                           m_tvalid,
  input  logic                           m_tready,
  // pos_x[31:0], pos_y[63:32], pos_z[95:64], front_x..z[143:96],
  // right_x..z[191:144], up_x..z[239:192], 16 bits each vector component
  output logic [ffc_pkg::DATA_OUT_W-1:0] m_tdata,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [ffc_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [ffc_pkg::CFG_DATA_W-1:0] cfg_data
);

  ffc_pkg::ffc_cmd_t  cmd;
  ffc_pkg::ffc_stat_t stat;

  // registers are simple flops, any write completes at once
  assign cfg_ready = 1'b1;

  ffc_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_tvalid),
    .in_ready (s_tready),
    .stat     (stat),
    .cmd      (cmd)
  );

  ffc_dp #(
    .POS_W (POS_WIDTH),
    .AFB   (ANGLE_FRAC_BITS),
    .VFB   (VEC_FRAC_BITS)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .in_data   (s_tdata),
    .cfg_valid (cfg_valid && cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cmd       (cmd),
    .stat      (stat),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .out_data  (m_tdata)
  );

  // one word in flight: the block drops ready right after taking a word
  a_single_word: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready)
    else $error("input taken while a word is in flight");

  // right vector has no y component
  a_right_y_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tdata[175:160] == 16'd0))
    else $error("right_y nonzero");

  // the initial basis build keeps the input closed right after reset
  a_init_closed: assert property (@(posedge clk)
    $fell(rst) |-> !s_tready)
    else $error("ready before initial basis built");

  // a new result is loaded only when the output register is free
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    cmd.out_load |-> (!m_tvalid || m_tready))
    else $error("result overwritten");

endmodule
